// ===== src/sapd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_pkg: shared constants and types for the servo angle to PWM duty unit
// Build-time settings, field widths, register indexes and the side-band
// record that rides along the divider pipeline.
// ----------------------------------------------------------------------------
package sapd_pkg;

    // Build-time settings
    localparam int DUTY_BITS     = 14;
    localparam int PWM_FREQ_HZ   = 50;
    localparam int PULSE_MIN_US  = 500;
    localparam int PULSE_MAX_US  = 2500;
    localparam int US_PER_SECOND = 1000000;

    // Field widths
    localparam int ANGLE_W    = 17;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Angle differences need one bit more than an angle
    localparam int DIFF_W  = ANGLE_W + 1;
    // Pulse limits (0..20000 us) and their difference as signed words
    localparam int PULSE_W = 16;
    // Products of the interpolation stage
    localparam int PROD_W  = DUTY_W + DIFF_W + 1;

    localparam int PWM_PERIOD = US_PER_SECOND / PWM_FREQ_HZ;
    localparam int PERIOD_W   = $clog2(PWM_PERIOD + 1);

    // Dividend: calibrated < 2^34, uncalibrated < 2^(32 + DUTY_BITS)
    localparam int NUM_W = 34 + DUTY_BITS;
    // Divisor: span * period, or the calibration angle span
    localparam int DEN_W = DIFF_W + PERIOD_W;
    // Partial remainder and shifted divisor
    localparam int DIV_W = (NUM_W > DEN_W + DUTY_BITS) ? NUM_W : DEN_W + DUTY_BITS;

    localparam int DUTY_FULL = (1 << DUTY_BITS) - 1;
    localparam logic [DUTY_W-1:0] DUTY_FULL_V = DUTY_W'(DUTY_FULL);

    localparam logic signed [PULSE_W-1:0] PULSE_MIN_S = PULSE_W'(PULSE_MIN_US);
    localparam logic signed [PULSE_W-1:0] PULSE_DIF_S = PULSE_W'(PULSE_MAX_US - PULSE_MIN_US);
    localparam logic [PERIOD_W-1:0]       PERIOD_V    = PERIOD_W'(PWM_PERIOD);

    // Duty for the minimum pulse, used when the angle limits are equal or crossed
    localparam longint MIN_PULSE_RAW  = (longint'(PULSE_MIN_US) << DUTY_BITS) / PWM_PERIOD;
    localparam bit     MIN_PULSE_SAT  = (MIN_PULSE_RAW > longint'(DUTY_FULL));
    localparam logic [DUTY_W-1:0] MIN_PULSE_DUTY =
        MIN_PULSE_SAT ? DUTY_FULL_V : DUTY_W'(MIN_PULSE_RAW);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ANGLE_LOW  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ANGLE_HIGH = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CAL_DUTY_LOW   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_CAL_DUTY_HIGH  = CFG_IDX_W'(6);

    // Per-transaction side band carried past the divider
    typedef struct packed {
        logic              angle_limited;
        logic              bypass;
        logic              bypass_sat;
        logic [DUTY_W-1:0] bypass_duty;
    } side_t;

endpackage
`default_nettype wire

// ===== src/sapd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_div: pipelined restoring divider
// Unsigned floor division with one quotient bit per stage. A leading stage
// flags quotients that do not fit in DUTY_BITS. All stages move together
// on the common enable.
// ----------------------------------------------------------------------------
module sapd_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [sapd_pkg::NUM_W-1:0]      in_num,
    input  logic [sapd_pkg::DEN_W-1:0]      in_den,
    input  sapd_pkg::side_t                 in_side,
    output logic                            out_valid,
    output logic [sapd_pkg::DUTY_BITS-1:0]  out_quo,
    output logic                            out_ovf,
    output sapd_pkg::side_t                 out_side
);
    import sapd_pkg::*;

    localparam int STAGES = DUTY_BITS + 1;

    logic                 valid_reg [STAGES];
    logic [DIV_W-1:0]     rem_reg   [STAGES];
    logic [DEN_W-1:0]     den_reg   [STAGES];
    logic [DUTY_BITS-1:0] quo_reg   [STAGES];
    logic                 ovf_reg   [STAGES];
    side_t                side_reg  [STAGES];

    logic [DIV_W-1:0] ovf_trial;
    logic [DIV_W-1:0] num_ext;

    // Overflow check: quotient >= 2^DUTY_BITS
    assign num_ext   = DIV_W'(in_num);
    assign ovf_trial = DIV_W'(in_den) << DUTY_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num_ext;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= (num_ext >= ovf_trial);
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s < STAGES; s++) begin : g_step
        logic [DIV_W-1:0]     trial;
        logic                 ge;
        logic [DIV_W-1:0]     rem_next;
        logic [DUTY_BITS-1:0] quo_next;

        always_comb begin
            trial    = DIV_W'(den_reg[s-1]) << (DUTY_BITS - s);
            ge       = (rem_reg[s-1] >= trial);
            rem_next = ge ? (rem_reg[s-1] - trial) : rem_reg[s-1];
            quo_next = quo_reg[s-1];
            quo_next[DUTY_BITS-s] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_reg[s-1];
                quo_reg[s]  <= quo_next;
                ovf_reg[s]  <= ovf_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_ovf   = ovf_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== src/servo_angle_to_pwm_duty_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_angle_to_pwm_duty_unit: servo angle to PWM compare value
// Clamps an angle to the configured limits and maps it to a duty word,
// by calibration points or by fixed pulse limits over the PWM period.
// ----------------------------------------------------------------------------
// The unit takes one angle per clock while no result waits on m_ready and
// returns one duty transaction per angle, in order, through DUTY_BITS + 6
// register stages: clamp, differences, products, dividend, then a restoring
// divider with one quotient bit per stage plus an overflow stage, then the
// output register. The whole pipeline holds while a result waits on m_ready.
// Configuration writes are always taken (cfg_ready is high) and act at once;
// write them only while no transaction is in flight. Writes to unused
// indexes are dropped.
module servo_angle_to_pwm_duty_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sapd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sapd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // angle in
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sapd_pkg::ANGLE_W-1:0]  s_angle,
    // duty out
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sapd_pkg::DUTY_W-1:0]          m_duty,
    output logic                                 m_angle_limited,
    output logic                                 m_duty_limited
);
    import sapd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] angle_min_reg;
    logic signed [ANGLE_W-1:0] angle_max_reg;
    logic                      calibrated_reg;
    logic signed [ANGLE_W-1:0] cal_angle_low_reg;
    logic signed [ANGLE_W-1:0] cal_angle_high_reg;
    logic [DUTY_W-1:0]         cal_duty_low_reg;
    logic [DUTY_W-1:0]         cal_duty_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_min_reg      <= ANGLE_W'(0);
            angle_max_reg      <= ANGLE_W'(18000);
            calibrated_reg     <= 1'b0;
            cal_angle_low_reg  <= ANGLE_W'(0);
            cal_angle_high_reg <= ANGLE_W'(18000);
            cal_duty_low_reg   <= '0;
            cal_duty_high_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ANGLE_MIN:      angle_min_reg      <= cfg_data;
                REG_ANGLE_MAX:      angle_max_reg      <= cfg_data;
                REG_CALIBRATED:     calibrated_reg     <= cfg_data[0];
                REG_CAL_ANGLE_LOW:  cal_angle_low_reg  <= cfg_data;
                REG_CAL_ANGLE_HIGH: cal_angle_high_reg <= cfg_data;
                REG_CAL_DUTY_LOW:   cal_duty_low_reg   <= cfg_data[DUTY_W-1:0];
                REG_CAL_DUTY_HIGH:  cal_duty_high_reg  <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances when the output register is free or drains
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Stage A: clamp to angle_max, then angle_min
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] clamp_hi;
    logic signed [ANGLE_W-1:0] clamp_angle;
    logic                      clamp_flag;

    always_comb begin
        clamp_hi    = (s_angle > angle_max_reg) ? angle_max_reg : s_angle;
        clamp_angle = (clamp_hi < angle_min_reg) ? angle_min_reg : clamp_hi;
        clamp_flag  = (s_angle > angle_max_reg) || (clamp_hi < angle_min_reg);
    end

    logic                      a_valid_reg;
    logic signed [ANGLE_W-1:0] a_angle_reg;
    logic                      a_alim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_angle_reg <= clamp_angle;
            a_alim_reg  <= clamp_flag;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: differences and segment tests
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] da_next;
    logic signed [DIFF_W-1:0] q_next;
    logic signed [DUTY_W:0]   dd_next;
    logic signed [DIFF_W-1:0] span_next;
    logic signed [DIFF_W-1:0] d_next;

    always_comb begin
        da_next   = DIFF_W'(a_angle_reg) - DIFF_W'(cal_angle_low_reg);
        q_next    = DIFF_W'(cal_angle_high_reg) - DIFF_W'(cal_angle_low_reg);
        dd_next   = $signed({1'b0, cal_duty_high_reg}) - $signed({1'b0, cal_duty_low_reg});
        span_next = DIFF_W'(angle_max_reg) - DIFF_W'(angle_min_reg);
        d_next    = DIFF_W'(a_angle_reg) - DIFF_W'(angle_min_reg);
    end

    logic                     b_valid_reg;
    logic                     b_alim_reg;
    logic signed [DIFF_W-1:0] b_da_reg;
    logic signed [DIFF_W-1:0] b_q_reg;
    logic signed [DUTY_W:0]   b_dd_reg;
    logic signed [DIFF_W-1:0] b_span_reg;
    logic signed [DIFF_W-1:0] b_d_reg;
    logic                     b_le_lo_reg;
    logic                     b_ge_hi_reg;
    logic                     b_span_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_alim_reg     <= a_alim_reg;
            b_da_reg       <= da_next;
            b_q_reg        <= q_next;
            b_dd_reg       <= dd_next;
            b_span_reg     <= span_next;
            b_d_reg        <= d_next;
            b_le_lo_reg    <= (a_angle_reg <= cal_angle_low_reg);
            b_ge_hi_reg    <= (a_angle_reg >= cal_angle_high_reg);
            b_span_pos_reg <= (span_next > 0);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: products, divisor and end-point bypass
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]           cal_p1;
    logic signed [PROD_W-1:0]           cal_p2;
    logic signed [PULSE_W+DIFF_W-1:0]   un_p1;
    logic signed [PULSE_W+DIFF_W-1:0]   un_p2;
    logic signed [DIFF_W+PERIOD_W:0]    un_den;
    logic signed [PROD_W-1:0]           p1_next;
    logic signed [PROD_W-1:0]           p2_next;
    logic [DEN_W-1:0]                   den_next;
    logic [DUTY_W-1:0]                  cal_end_duty;
    side_t                              side_next;

    always_comb begin
        // cal: dl * (hi - lo) + (a - lo) * (dh - dl)
        cal_p1 = $signed({1'b0, cal_duty_low_reg}) * b_q_reg;
        cal_p2 = b_da_reg * b_dd_reg;
        // uncal: PULSE_MIN * span + (PULSE_MAX - PULSE_MIN) * (a - amin)
        un_p1  = PULSE_MIN_S * b_span_reg;
        un_p2  = PULSE_DIF_S * b_d_reg;
        un_den = b_span_reg * $signed({1'b0, PERIOD_V});

        cal_end_duty = b_le_lo_reg ? cal_duty_low_reg : cal_duty_high_reg;
        side_next.angle_limited = b_alim_reg;

        if (calibrated_reg) begin
            p1_next  = cal_p1;
            p2_next  = cal_p2;
            den_next = DEN_W'(b_q_reg);
            side_next.bypass      = b_le_lo_reg || b_ge_hi_reg;
            side_next.bypass_sat  = (cal_end_duty > DUTY_FULL_V);
            side_next.bypass_duty = (cal_end_duty > DUTY_FULL_V) ? DUTY_FULL_V : cal_end_duty;
        end else begin
            p1_next  = PROD_W'(un_p1);
            p2_next  = PROD_W'(un_p2);
            den_next = DEN_W'(un_den);
            // equal or crossed limits give the minimum pulse
            side_next.bypass      = !b_span_pos_reg;
            side_next.bypass_sat  = MIN_PULSE_SAT;
            side_next.bypass_duty = MIN_PULSE_DUTY;
        end
    end

    logic                     c_valid_reg;
    logic signed [PROD_W-1:0] c_p1_reg;
    logic signed [PROD_W-1:0] c_p2_reg;
    logic [DEN_W-1:0]         c_den_reg;
    logic                     c_scale_reg;
    side_t                    c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_p1_reg    <= p1_next;
            c_p2_reg    <= p2_next;
            c_den_reg   <= den_next;
            c_scale_reg <= !calibrated_reg;
            c_side_reg  <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: dividend; uncalibrated pulses scale by 2^DUTY_BITS
    // ------------------------------------------------------------------
    logic signed [PROD_W:0] sum;
    logic [NUM_W-1:0]       num_next;

    always_comb begin
        sum      = (PROD_W+1)'(c_p1_reg) + (PROD_W+1)'(c_p2_reg);
        num_next = c_scale_reg ? (NUM_W'(sum) << DUTY_BITS) : NUM_W'(sum);
    end

    logic             d_valid_reg;
    logic [NUM_W-1:0] d_num_reg;
    logic [DEN_W-1:0] d_den_reg;
    side_t            d_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_num_reg  <= num_next;
            d_den_reg  <= c_den_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic                 div_valid;
    logic [DUTY_BITS-1:0] div_quo;
    logic                 div_ovf;
    side_t                div_side;

    sapd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_den    (d_den_reg),
        .in_side   (d_side_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_ovf   (div_ovf),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Output register: pick bypass or quotient, saturate
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] duty_next;
    logic              dlim_next;

    always_comb begin
        if (div_side.bypass) begin
            duty_next = div_side.bypass_duty;
            dlim_next = div_side.bypass_sat;
        end else if (div_ovf) begin
            duty_next = DUTY_FULL_V;
            dlim_next = 1'b1;
        end else begin
            duty_next = DUTY_W'(div_quo);
            dlim_next = 1'b0;
        end
    end

    logic [DUTY_W-1:0] m_duty_reg;
    logic              m_alim_reg;
    logic              m_dlim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_duty_reg <= duty_next;
            m_alim_reg <= div_side.angle_limited;
            m_dlim_reg <= dlim_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_duty          = m_duty_reg;
    assign m_angle_limited = m_alim_reg;
    assign m_duty_limited  = m_dlim_reg;

`ifndef NO_ASSERTIONS
    // duty never above the full-scale compare value
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty <= DUTY_FULL_V))
        else $error("duty above full scale");

    // a saturated result carries the full-scale value
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_duty_limited) |-> (m_duty == DUTY_FULL_V))
        else $error("saturation flag without full-scale duty");

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !div_valid && !d_valid_reg))
        else $error("valid left set by reset");

    // a finished division moves into the output register when the pipe advances
    a_div_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && adv) |=> m_valid)
        else $error("divider result lost");
`endif

endmodule
`default_nettype wire

// ===== tb/servo_angle_to_pwm_duty_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_to_pwm_duty_unit_tb: self-checking bench for the duty unit
// Streams angles through the unit under a series of register settings.
// Directed angles come first, then random ones. A local predictor computes
// the duty and clamp flags for every accepted angle, and the monitor checks
// each result against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module servo_angle_to_pwm_duty_unit_tb;
    import sapd_pkg::*;

    localparam int PIPE_DEPTH  = DUTY_BITS + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 82;
    localparam int MAX_PRINTS  = 20;

    // Index with no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              angle_limited;
        logic              duty_limited;
    } duty_rec_t;

    // Clock, reset and DUT ports
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [ANGLE_W-1:0]   s_angle = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [DUTY_W-1:0]           m_duty;
    logic                        m_angle_limited;
    logic                        m_duty_limited;

    // Predictor copy of the registers, reset values
    logic signed [ANGLE_W-1:0]   lim_min = ANGLE_W'(0);
    logic signed [ANGLE_W-1:0]   lim_max = ANGLE_W'(18000);
    logic                        cal_mode = 1'b0;
    logic signed [ANGLE_W-1:0]   cal_lo = ANGLE_W'(0);
    logic signed [ANGLE_W-1:0]   cal_hi = ANGLE_W'(18000);
    logic [DUTY_W-1:0]           cal_dlo = '0;
    logic [DUTY_W-1:0]           cal_dhi = '0;

    logic signed [ANGLE_W-1:0]   pending_angles[$];
    duty_rec_t                   expected_duties[$];

    bit no_idle = 1'b0;
    int tx_pause = 0;
    int rx_pause = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int items_issued = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cal_results = 0;
    int alim_results = 0;
    int dlim_results = 0;
    int regs_written = 0;

    servo_angle_to_pwm_duty_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_angle         (s_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_duty          (m_duty),
        .m_angle_limited (m_angle_limited),
        .m_duty_limited  (m_duty_limited)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // floor(n / d) for d > 0
    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    // Duty word and clamp flags for one angle under the current registers
    function automatic duty_rec_t predict_duty(logic signed [ANGLE_W-1:0] angle_in);
        longint    a, amin, amax, lo, hi, span, num, den, q, top;
        duty_rec_t rec;
        a    = angle_in;
        amin = lim_min;
        amax = lim_max;
        top  = (longint'(1) << DUTY_BITS) - 1;
        rec  = '0;
        // max clamp first, so crossed limits end at angle_min
        if (a > amax) begin
            a = amax;
            rec.angle_limited = 1'b1;
        end
        if (a < amin) begin
            a = amin;
            rec.angle_limited = 1'b1;
        end
        if (cal_mode) begin
            lo = cal_lo;
            hi = cal_hi;
            if (a <= lo) begin
                q = cal_dlo;
            end else if (a >= hi) begin
                q = cal_dhi;
            end else begin
                q = longint'(cal_dlo) +
                    div_floor((a - lo) * (longint'(cal_dhi) - longint'(cal_dlo)), hi - lo);
            end
        end else begin
            span = amax - amin;
            if (span <= 0) begin
                num = longint'(PULSE_MIN_US) << DUTY_BITS;
                den = PWM_PERIOD;
            end else begin
                num = (longint'(PULSE_MIN_US) * span +
                       longint'(PULSE_MAX_US - PULSE_MIN_US) * (a - amin)) << DUTY_BITS;
                den = span * PWM_PERIOD;
            end
            q = div_floor(num, den);
        end
        if (q < 0) q = 0;
        if (q > top) begin
            q = top;
            rec.duty_limited = 1'b1;
        end
        rec.duty = DUTY_W'(q);
        return rec;
    endfunction

    // Idle length: mostly none, mostly short, now and then long
    function automatic int rand_pause(int idle_pct);
        if (no_idle || $urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic int pick_cfg_angle();
        case ($urandom_range(0, 9))
            0:       return -36000;
            1:       return 36000;
            2:       return int'($signed(ANGLE_W'($urandom)));
            default: return int'($urandom_range(0, 72000)) - 36000;
        endcase
    endfunction

    function automatic int pick_cfg_duty();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return (1 << DUTY_BITS) - 1;
            3, 4:    return int'($urandom_range(0, 65535));
            default: return int'($urandom_range(0, (1 << DUTY_BITS) - 1));
        endcase
    endfunction

    // Random angle, biased around the limits and calibration points
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int r, v, lo_b, hi_b, mn, mx, cl, ch;
        r  = $urandom_range(0, 99);
        mn = lim_min;
        mx = lim_max;
        cl = cal_lo;
        ch = cal_hi;
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0:       v = mn;
                1:       v = mx;
                2:       v = cl;
                default: v = ch;
            endcase
            v = v + int'($urandom_range(0, 2)) - 1;
        end else if (r < 16) begin
            v = int'($urandom_range(0, 131071)) - 65536;
        end else if (r < 20) begin
            v = $urandom_range(0, 1) ? 36000 : -36000;
        end else begin
            lo_b = ((mn < mx) ? mn : mx) - 3000;
            hi_b = ((mn < mx) ? mx : mn) + 3000;
            if (cal_mode) begin
                if (cl - 3000 < lo_b) lo_b = cl - 3000;
                if (ch + 3000 > hi_b) hi_b = ch + 3000;
            end
            if (lo_b < -65536) lo_b = -65536;
            if (hi_b > 65535) hi_b = 65535;
            v = lo_b + int'($urandom_range(0, hi_b - lo_b));
        end
        return ANGLE_W'(v);
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // One register write; valid stays up for back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ANGLE_MIN:      lim_min  = data[ANGLE_W-1:0];
            REG_ANGLE_MAX:      lim_max  = data[ANGLE_W-1:0];
            REG_CALIBRATED:     cal_mode = data[0];
            REG_CAL_ANGLE_LOW:  cal_lo   = data[ANGLE_W-1:0];
            REG_CAL_ANGLE_HIGH: cal_hi   = data[ANGLE_W-1:0];
            REG_CAL_DUTY_LOW:   cal_dlo  = data[DUTY_W-1:0];
            REG_CAL_DUTY_HIGH:  cal_dhi  = data[DUTY_W-1:0];
            default: ;
        endcase
        regs_written++;
    endtask

    // Full register set; unused upper data bits carry noise
    task automatic apply_settings(int amin, int amax, bit cal, int clo, int chi,
                                  int dlo, int dhi);
        @(posedge aclk);
        write_reg(REG_ANGLE_MIN, CFG_DATA_W'(amin));
        write_reg(REG_ANGLE_MAX, CFG_DATA_W'(amax));
        write_reg(REG_CALIBRATED, {(CFG_DATA_W-1)'($urandom), cal});
        write_reg(REG_CAL_ANGLE_LOW, CFG_DATA_W'(clo));
        write_reg(REG_CAL_ANGLE_HIGH, CFG_DATA_W'(chi));
        write_reg(REG_CAL_DUTY_LOW, {1'($urandom), DUTY_W'(dlo)});
        write_reg(REG_CAL_DUTY_HIGH, {1'($urandom), DUTY_W'(dhi)});
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        int amin, amax, clo, chi, t;
        amin = pick_cfg_angle();
        amax = pick_cfg_angle();
        if (amin > amax && $urandom_range(0, 4) != 0) begin
            t = amin; amin = amax; amax = t;
        end
        if ($urandom_range(0, 11) == 0) amax = amin;
        clo = pick_cfg_angle();
        chi = pick_cfg_angle();
        if (clo > chi && $urandom_range(0, 6) != 0) begin
            t = clo; clo = chi; chi = t;
        end
        apply_settings(amin, amax, 1'($urandom), clo, chi, pick_cfg_duty(), pick_cfg_duty());
    endtask

    // Hold off until every queued angle is sent and every result is back
    task automatic wait_drained();
        while (pending_angles.size() != 0 || items_issued > results_checked)
            @(posedge aclk);
    endtask

    // Angle driver: presents queued angles, predicts on each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_duties.push_back(predict_duty(s_angle));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_pause != 0) begin
                    tx_pause--;
                    s_valid <= 1'b0;
                end else if (pending_angles.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_angle  <= pending_angles.pop_front();
                    items_issued++;
                    tx_pause = rand_pause(40);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction, stalls at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_duties.size() == 0) begin
                    report_mismatch($sformatf("unexpected result duty %0d", m_duty));
                end else begin
                    if (m_duty !== expected_duties[0].duty)
                        report_mismatch($sformatf("result %0d duty got %0d expected %0d",
                            results_checked, m_duty, expected_duties[0].duty));
                    if (m_angle_limited !== expected_duties[0].angle_limited)
                        report_mismatch($sformatf("result %0d angle_limited got %b expected %b",
                            results_checked, m_angle_limited,
                            expected_duties[0].angle_limited));
                    if (m_duty_limited !== expected_duties[0].duty_limited)
                        report_mismatch($sformatf("result %0d duty_limited got %b expected %b",
                            results_checked, m_duty_limited,
                            expected_duties[0].duty_limited));
                    if (expected_duties[0].angle_limited) alim_results++;
                    if (expected_duties[0].duty_limited) dlim_results++;
                    if (cal_mode) cal_results++;
                    void'(expected_duties.pop_front());
                end
                results_checked++;
            end
            if (rx_pause == 0) rx_pause = rand_pause(25);
            if (rx_pause != 0) begin
                rx_pause--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL servo_angle_to_pwm_duty_unit");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: uncalibrated over 0..180 degrees, plus raw bit extremes
        pending_angles = '{ANGLE_W'(0), ANGLE_W'(18000), ANGLE_W'(9000), ANGLE_W'(-1),
                           ANGLE_W'(18001), ANGLE_W'(-65536), ANGLE_W'(65535)};
        wait_drained();

        // Widest legal limits
        apply_settings(-36000, 36000, 1'b0, 0, 18000, 0, 0);
        pending_angles = '{ANGLE_W'(-36000), ANGLE_W'(36000), ANGLE_W'(1)};
        wait_drained();
        @(posedge aclk);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;

        // Equal limits give the minimum pulse
        apply_settings(5000, 5000, 1'b0, 0, 18000, 0, 0);
        pending_angles = '{ANGLE_W'(4999), ANGLE_W'(5000)};
        wait_drained();

        // Crossed limits: the min clamp wins
        apply_settings(10000, -10000, 1'b0, 0, 18000, 0, 0);
        pending_angles = '{ANGLE_W'(20000), ANGLE_W'(0)};
        wait_drained();

        // Calibrated, rising duties up to saturation
        apply_settings(-36000, 36000, 1'b1, 0, 18000, 1000, 65535);
        pending_angles = '{ANGLE_W'(-100), ANGLE_W'(0), ANGLE_W'(9000),
                           ANGLE_W'(18000), ANGLE_W'(25000)};
        wait_drained();

        // Calibrated, reversed duties
        apply_settings(-36000, 36000, 1'b1, -18000, 18000, 65535, 0);
        pending_angles = '{ANGLE_W'(-18000), ANGLE_W'(0), ANGLE_W'(17999), ANGLE_W'(18000)};
        wait_drained();

        // Calibrated, crossed calibration angles: the low-end test comes first
        apply_settings(-36000, 36000, 1'b1, 10000, -10000, 100, 200);
        pending_angles = '{ANGLE_W'(-20000), ANGLE_W'(0), ANGLE_W'(10000)};
        wait_drained();

        // Random settings and angles
        for (int p = 0; p < RAND_PHASES; p++) begin
            random_settings();
            no_idle = ($urandom_range(0, 3) == 0);
            n = PHASE_ITEMS;
            for (int i = 0; i < n; i++) pending_angles.push_back(pick_angle());
            wait_drained();
        end
        no_idle = 1'b0;

        // Let anything stray come out
        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (expected_duties.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_duties.size()));

        $display("covered %0d angles, %0d results (%0d calibrated), %0d register writes",
                 items_sent, results_checked, cal_results, regs_written);
        $display("angle clamps %0d, duty saturations %0d, mismatches %0d",
                 alim_results, dlim_results, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS servo_angle_to_pwm_duty_unit");
        end else begin
            $display("FAIL servo_angle_to_pwm_duty_unit");
        end
        $finish;
    end

endmodule
